### src/tccw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg: text console cursor writer definitions
// Opcodes, control characters, cell constants and register map.
// ----------------------------------------------------------------------------
package tccw_pkg;

   typedef enum logic [1:0] {
      OP_WRITE_CHAR = 2'd0,
      OP_SET_CURSOR = 2'd1,
      OP_READ_CELL  = 2'd2,
      OP_CLEAR      = 2'd3
   } opcode_type;

   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_BLANK     = 8'h20;

   localparam logic [7:0]  RESET_ATTR = 8'h0F;
   localparam logic [15:0] RESET_CELL = 16'h0F20;

   localparam int          CELL_W     = 16;
   localparam int          CSR_ADDR_W = 3;
   localparam logic        REG_ATTRIBUTE_COLOR = 1'b0;

endpackage

### src/tccw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tccw_ram #(
   parameter int  DATA_W = 16,
   parameter int  DEPTH  = 2000,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/text_console_cursor_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_writer_unit: character-cell text console
// Screen store and cursor under a small sequencer; one address unit serves
// writes and reads, and one RAM port pair serves writes, reads, scroll copy and clear sweeps.
// ----------------------------------------------------------------------------
// Sequence: a start is taken only while idle. Write char, return, backspace,
//   newline and set cursor go from decode to done, where the result is strobed,
//   unless a scroll follows; read cell goes through decode, read and done.
// Scroll copies the rows up and blanks the last row; clear blanks the store.
// After reset busy stays high while the store is filled with blanks;
//   results cannot be stalled.
module text_console_cursor_writer_unit #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_opcode,
   input  logic [7:0]                      req_char_code,
   input  logic [7:0]                      req_target_row,
   input  logic [7:0]                      req_target_col,
   output logic                            rsp_valid,
   output logic [4:0]                      rsp_cursor_row,
   output logic [6:0]                      rsp_cursor_col,
   output logic [10:0]                     rsp_cursor_position,
   output logic [15:0]                     rsp_cell_data,
   output logic                            rsp_scrolled,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tccw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int COPY_COUNT = SCREEN_WIDTH * (SCREEN_HEIGHT - 1);
   localparam int LAST_ROW   = SCREEN_HEIGHT - 1;
   localparam int LAST_COL   = SCREEN_WIDTH - 1;
   localparam int ROW_W      = $clog2(SCREEN_HEIGHT);
   localparam int COL_W      = $clog2(SCREEN_WIDTH);
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int SRC_W      = $clog2(CELL_COUNT + 1);

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_DECODE = 7'b0000100,
      ST_READ   = 7'b0001000,
      ST_COPY   = 7'b0010000,
      ST_BLANK  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(r) * ADDR_W'(SCREEN_WIDTH);
      return base + ADDR_W'(c);
   endfunction

   state_type                   state_ff, state_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic [COL_W-1:0]            col_ff, col_in;
   logic [SRC_W-1:0]            src_ff, src_in;
   logic [ADDR_W-1:0]           dst_ff, dst_in;
   logic                        first_ff, first_in;
   logic [15:0]                 cell_ff, cell_in;
   logic                        scrolled_ff, scrolled_in;
   logic [7:0]                  attr_ff;
   logic [1:0]                  op_ff;
   logic [7:0]                  ch_ff;
   logic [7:0]                  trow_ff;
   logic [7:0]                  tcol_ff;

   logic [ROW_W-1:0]            sat_row;
   logic [COL_W-1:0]            sat_col;
   logic [COL_W-1:0]            col_dec;
   logic [ROW_W-1:0]            sel_row;
   logic [COL_W-1:0]            sel_col;
   logic [ADDR_W-1:0]           cur_addr;
   logic [15:0]                 blank_cell;
   logic                        advance;

   logic                        ram_we;
   logic [ADDR_W-1:0]           ram_waddr;
   logic [15:0]                 ram_wdata;
   logic                        ram_re;
   logic [ADDR_W-1:0]           ram_raddr;
   logic [15:0]                 ram_rdata;
   logic                        csr_write;

   // Configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tccw_pkg::RESET_ATTR;
      end else if (csr_write && paddr[2] == tccw_pkg::REG_ATTRIBUTE_COLOR) begin
         attr_ff <= pwdata[7:0];
      end
   end

   assign prdata = (paddr[2] == tccw_pkg::REG_ATTRIBUTE_COLOR) ? {24'd0, attr_ff} : 32'd0;

   // Address unit
   assign sat_row = ({1'b0, trow_ff} > 9'(LAST_ROW)) ? ROW_W'(LAST_ROW) : ROW_W'(trow_ff);
   assign sat_col = ({1'b0, tcol_ff} > 9'(LAST_COL)) ? COL_W'(LAST_COL) : COL_W'(tcol_ff);
   assign col_dec = (col_ff == '0) ? '0 : col_ff - 1'b1;

   always_comb begin
      sel_row = row_ff;
      sel_col = col_ff;
      if (op_ff == tccw_pkg::OP_READ_CELL) begin
         sel_row = sat_row;
         sel_col = sat_col;
      end else if (ch_ff == tccw_pkg::CHAR_BACKSPACE) begin
         sel_col = col_dec;
      end
   end

   assign cur_addr   = cell_addr(sel_row, sel_col);
   assign blank_cell = {attr_ff, tccw_pkg::CHAR_BLANK};

   // Newline, or a printable character in the last column, moves to the next row
   assign advance = (ch_ff == tccw_pkg::CHAR_NEWLINE) ||
                    (ch_ff != tccw_pkg::CHAR_RETURN && ch_ff != tccw_pkg::CHAR_BACKSPACE &&
                     col_ff == COL_W'(LAST_COL));

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      first_in    = first_ff;
      cell_in     = cell_ff;
      scrolled_in = scrolled_ff;
      ram_we      = 1'b0;
      ram_waddr   = dst_ff;
      ram_wdata   = blank_cell;
      ram_re      = 1'b0;
      ram_raddr   = cur_addr;

      case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = tccw_pkg::RESET_CELL;
            dst_in    = dst_ff + 1'b1;
            if (dst_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cell_in     = '0;
            scrolled_in = 1'b0;
            state_in    = ST_DONE;
            case (op_ff)
               tccw_pkg::OP_WRITE_CHAR: begin
                  if (ch_ff == tccw_pkg::CHAR_RETURN) begin
                     col_in = '0;
                  end else if (ch_ff == tccw_pkg::CHAR_BACKSPACE) begin
                     col_in    = col_dec;
                     ram_we    = 1'b1;
                     ram_waddr = cur_addr;
                  end else begin
                     if (ch_ff != tccw_pkg::CHAR_NEWLINE) begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_addr;
                        ram_wdata = {attr_ff, ch_ff};
                        col_in    = col_ff + 1'b1;
                     end
                     if (advance) begin
                        col_in = '0;
                        if (row_ff == ROW_W'(LAST_ROW)) begin
                           // Scroll: copy rows up, then blank the last row
                           src_in      = SRC_W'(SCREEN_WIDTH);
                           dst_in      = '0;
                           first_in    = 1'b1;
                           scrolled_in = 1'b1;
                           state_in    = ST_COPY;
                        end else begin
                           row_in = row_ff + 1'b1;
                        end
                     end
                  end
               end
               tccw_pkg::OP_SET_CURSOR: begin
                  row_in = sat_row;
                  col_in = sat_col;
               end
               tccw_pkg::OP_READ_CELL: begin
                  ram_re   = 1'b1;
                  state_in = ST_READ;
               end
               tccw_pkg::OP_CLEAR: begin
                  row_in   = '0;
                  col_in   = '0;
                  dst_in   = '0;
                  state_in = ST_BLANK;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_READ: begin
            cell_in  = ram_rdata;
            state_in = ST_DONE;
         end
         ST_COPY: begin
            first_in = 1'b0;
            if (src_ff < SRC_W'(CELL_COUNT)) begin
               ram_re    = 1'b1;
               ram_raddr = src_ff[ADDR_W-1:0];
               src_in    = src_ff + 1'b1;
            end
            // Each write takes the RAM data registered by the previous read
            if (!first_ff) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
               dst_in    = dst_ff + 1'b1;
               if (dst_ff == ADDR_W'(COPY_COUNT - 1)) begin
                  state_in = ST_BLANK;
               end
            end
         end
         ST_BLANK: begin
            ram_we = 1'b1;
            dst_in = dst_ff + 1'b1;
            if (dst_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         row_ff      <= '0;
         col_ff      <= '0;
         src_ff      <= '0;
         dst_ff      <= '0;
         first_ff    <= 1'b0;
         scrolled_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         src_ff      <= src_in;
         dst_ff      <= dst_in;
         first_ff    <= first_in;
         scrolled_ff <= scrolled_in;
      end
   end

   // Transaction payload and read result
   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (state_ff == ST_IDLE && start) begin
         op_ff   <= req_opcode;
         ch_ff   <= req_char_code;
         trow_ff <= req_target_row;
         tcol_ff <= req_target_col;
      end
   end

   tccw_ram #(
      .DATA_W (tccw_pkg::CELL_W),
      .DEPTH  (CELL_COUNT)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = (state_ff == ST_DONE);
   assign rsp_cursor_row      = 5'(row_ff);
   assign rsp_cursor_col      = 7'(col_ff);
   assign rsp_cursor_position = 11'(cell_addr(row_ff, col_ff));
   assign rsp_cell_data       = cell_ff;
   assign rsp_scrolled        = scrolled_ff;

`ifndef ASSERT_OFF
   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (row_ff <= ROW_W'(LAST_ROW)) && (col_ff <= COL_W'(LAST_COL)))
      else $error("cursor out of screen range");

   a_scroll_home: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> (row_ff == ROW_W'(LAST_ROW)) && (col_ff == '0))
      else $error("scroll left cursor off the start of the last row");

   a_copy_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) && ram_we |-> dst_ff < ADDR_W'(COPY_COUNT))
      else $error("scroll copy wrote past the copied rows");
`endif

endmodule
